// ===== hw/rtl/assert_macros.svh =====
// ----------------------------------------------------------------------------
// assert_macros
// concurrent assertion helpers shared by the rtl
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// checked only out of reset
`define ITP_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// checked during reset too
`define ITP_ASSERT_RST(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== hw/rtl/itp_pkg.sv =====
// ----------------------------------------------------------------------------
// itp_pkg
// shared types, constants and the threshold table of the timing packer
// ----------------------------------------------------------------------------
package itp_pkg;

  localparam int LEVEL_COUNT   = 168;
  localparam int LISTED_LEVELS = 168;
  localparam int QUEUE_DEPTH   = 2;
  localparam int STORE_DEPTH   = 32;

  localparam logic [7:0]  CODE_OFFSET = 8'd30;
  localparam logic [7:0]  RUN_MARKER  = 8'h01;
  localparam logic [7:0]  CODE_MAX    = 8'hFF;
  localparam logic [7:0]  RUN_LIMIT   = 8'd255;
  localparam logic [7:0]  NEAR_LIMIT  = 8'd2;
  localparam logic [15:0] TICK_MAX    = 16'hFFFF;
  localparam logic [7:0]  LEVEL_LAST  = 8'(LEVEL_COUNT - 1);

  typedef struct packed {
    logic       flush;
    logic [7:0] code;
  } itp_rec_t;

  typedef struct packed {
    logic full;
    logic empty;
  } itp_qstat_t;

  localparam logic [15:0] LEVEL_TABLE [LISTED_LEVELS] = '{
    16'd205, 16'd213, 16'd220, 16'd228, 16'd236, 16'd244, 16'd253, 16'd262,
    16'd271, 16'd280, 16'd290, 16'd300, 16'd311, 16'd322, 16'd333, 16'd345,
    16'd357, 16'd369, 16'd382, 16'd395, 16'd409, 16'd424, 16'd439, 16'd454,
    16'd470, 16'd486, 16'd503, 16'd521, 16'd539, 16'd558, 16'd578, 16'd598,
    16'd619, 16'd640, 16'd663, 16'd686, 16'd710, 16'd735, 16'd761, 16'd787,
    16'd815, 16'd843, 16'd873, 16'd904, 16'd935, 16'd968, 16'd1002, 16'd1037,
    16'd1073, 16'd1111, 16'd1150, 16'd1190, 16'd1232, 16'd1275, 16'd1319, 16'd1366,
    16'd1413, 16'd1463, 16'd1514, 16'd1567, 16'd1622, 16'd1679, 16'd1738, 16'd1798,
    16'd1861, 16'd1927, 16'd1994, 16'd2064, 16'd2136, 16'd2211, 16'd2288, 16'd2368,
    16'd2451, 16'd2537, 16'd2626, 16'd2718, 16'd2813, 16'd2911, 16'd3013, 16'd3119,
    16'd3228, 16'd3341, 16'd3458, 16'd3579, 16'd3704, 16'd3834, 16'd3968, 16'd4107,
    16'd4251, 16'd4400, 16'd4554, 16'd4713, 16'd4878, 16'd5049, 16'd5226, 16'd5408,
    16'd5598, 16'd5794, 16'd5997, 16'd6206, 16'd6424, 16'd6648, 16'd6881, 16'd7122,
    16'd7371, 16'd7629, 16'd7896, 16'd8173, 16'd8459, 16'd8755, 16'd9061, 16'd9379,
    16'd9707, 16'd10047, 16'd10398, 16'd10762, 16'd11139, 16'd11529, 16'd11932,
    16'd12350,
    16'd12782, 16'd13230, 16'd13693, 16'd14172, 16'd14668, 16'd15181, 16'd15713,
    16'd16263,
    16'd16832, 16'd17421, 16'd18031, 16'd18662, 16'd19315, 16'd19991, 16'd20691,
    16'd21415,
    16'd22165, 16'd22940, 16'd23743, 16'd24574, 16'd25434, 16'd26325, 16'd27246,
    16'd28200,
    16'd29187, 16'd30208, 16'd31265, 16'd32360, 16'd33492, 16'd34665, 16'd35878,
    16'd37134,
    16'd38433, 16'd39779, 16'd41171, 16'd42612, 16'd44103, 16'd45647, 16'd47245,
    16'd48898,
    16'd50610, 16'd52381, 16'd54214, 16'd56112, 16'd58076, 16'd60108, 16'd62212,
    16'd64390
  };

  // entries past the listed ones repeat the last threshold
  function automatic logic [15:0] level_thr(input logic [7:0] idx);
    logic [15:0] val;
    if (int'(idx) >= LISTED_LEVELS) begin
      val = LEVEL_TABLE[LISTED_LEVELS - 1];
    end else begin
      val = LEVEL_TABLE[idx];
    end
    return val;
  endfunction

endpackage

// ===== hw/rtl/itp_front.sv =====
// ----------------------------------------------------------------------------
// itp_front
// takes input beats and quantises tick counts by a stepwise threshold search
// ----------------------------------------------------------------------------
module itp_front import itp_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        push,
  output logic        full,
  input  logic        in_operation,
  input  logic [15:0] in_ticks,
  output logic        q_wr,
  output itp_rec_t    q_data,
  input  itp_qstat_t  q_stat
);

  typedef enum logic [1:0] {F_IDLE, F_SRCH, F_PUSH} fstate_t;

  fstate_t     state_r;
  logic        flush_r;
  logic [15:0] ticks_r;
  logic [7:0]  lo_r;
  logic [7:0]  hi_r;
  logic [7:0]  code_r;

  logic [7:0]  mid;
  logic [15:0] thr_mid;
  logic        done;
  logic [7:0]  code_c;

  assign mid     = lo_r + ((hi_r - lo_r) >> 1);
  assign thr_mid = level_thr(mid);

  always_comb begin
    done   = 1'b1;
    code_c = lo_r + CODE_OFFSET;
    if (flush_r) begin
      code_c = 8'h00;
    end else if (ticks_r == 16'h0000) begin
      code_c = 8'h00;
    end else if (ticks_r <= level_thr(8'd0)) begin
      code_c = CODE_OFFSET;
    end else if (ticks_r == TICK_MAX) begin
      code_c = CODE_MAX;
    end else if (ticks_r >= level_thr(LEVEL_LAST)) begin
      code_c = LEVEL_LAST + CODE_OFFSET;
    end else if ((hi_r - lo_r) > 8'd1) begin
      done = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= F_IDLE;
    end else begin
      unique case (state_r)
        F_IDLE: begin
          if (push) begin
            flush_r <= in_operation;
            ticks_r <= in_ticks;
            lo_r    <= 8'd0;
            hi_r    <= LEVEL_LAST;
            state_r <= F_SRCH;
          end
        end
        F_SRCH: begin
          if (done) begin
            code_r  <= code_c;
            state_r <= F_PUSH;
          end else if (ticks_r >= thr_mid) begin
            lo_r <= mid;
          end else begin
            hi_r <= mid;
          end
        end
        F_PUSH: begin
          if (!q_stat.full) begin
            state_r <= F_IDLE;
          end
        end
        default: state_r <= F_IDLE;
      endcase
    end
  end

  assign full         = (state_r != F_IDLE);
  assign q_wr         = (state_r == F_PUSH) && !q_stat.full;
  assign q_data.flush = flush_r;
  assign q_data.code  = code_r;

endmodule

// ===== hw/rtl/itp_queue.sv =====
// ----------------------------------------------------------------------------
// itp_queue
// short record queue between the front and the back
// ----------------------------------------------------------------------------
module itp_queue import itp_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       wr_en,
  input  itp_rec_t   wr_data,
  input  logic       rd_en,
  output itp_rec_t   rd_data,
  output itp_qstat_t stat
);

  localparam int AW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CW = $clog2(QUEUE_DEPTH + 1);
  localparam logic [AW-1:0] PTR_LAST = AW'(QUEUE_DEPTH - 1);
  localparam logic [CW-1:0] CNT_FULL = CW'(QUEUE_DEPTH);

  itp_rec_t      mem_r [QUEUE_DEPTH];
  logic [AW-1:0] wp_r;
  logic [AW-1:0] rp_r;
  logic [CW-1:0] cnt_r;
  logic          do_wr;
  logic          do_rd;

  assign stat.full  = (cnt_r == CNT_FULL);
  assign stat.empty = (cnt_r == '0);
  assign do_wr      = wr_en && !stat.full;
  assign do_rd      = rd_en && !stat.empty;
  assign rd_data    = mem_r[rp_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (do_wr) begin
        mem_r[wp_r] <= wr_data;
        wp_r        <= (wp_r == PTR_LAST) ? '0 : wp_r + 1'b1;
      end
      if (do_rd) begin
        rp_r <= (rp_r == PTR_LAST) ? '0 : rp_r + 1'b1;
      end
      if (do_wr && !do_rd) begin
        cnt_r <= cnt_r + 1'b1;
      end else if (do_rd && !do_wr) begin
        cnt_r <= cnt_r - 1'b1;
      end
    end
  end

endmodule

// ===== hw/rtl/itp_back.sv =====
// ----------------------------------------------------------------------------
// itp_back
// run coder: collects code pairs as bits and emits the packed byte stream
// ----------------------------------------------------------------------------
module itp_back import itp_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  itp_rec_t   q_data,
  input  itp_qstat_t q_stat,
  output logic       q_rd,
  output logic       empty,
  input  logic       pop,
  output logic [7:0] out_byte,
  output logic       out_last
);

  localparam int SAW = $clog2(STORE_DEPTH);

  typedef enum logic [3:0] {
    B_IDLE, B_PUSH, B_END, B_VAL1, B_VAL2, B_HDR, B_RD, B_ST, B_TAIL, B_FIN
  } bstate_t;

  bstate_t        state_r;
  logic [7:0]     first_r;
  logic [7:0]     second_r;
  logic [7:0]     cnt_r;
  logic [7:0]     cur_r;
  logic [2:0]     pbits_r;
  logic [1:0]     plast_r;
  logic [1:0]     pi_r;
  logic           tail_v_r;
  logic [7:0]     tail_r;
  logic [7:0]     after_r;
  logic [1:0]     hdr_r;
  logic [SAW-1:0] bi_r;
  logic           ov_r;
  logic [7:0]     ob_r;
  logic           ol_r;
  logic [7:0]     store [STORE_DEPTH];
  logic [7:0]     rdata_r;

  logic           slot;
  logic           emit;
  logic [7:0]     eb;
  logic           el;
  logic [7:0]     code;
  logic [2:0]     pos;
  logic           bit_v;
  logic [7:0]     wbyte;
  logic [7:0]     cnt_inc;
  logic [SAW-1:0] last_idx;
  logic           st_wr;

  function automatic logic near_code(input logic [7:0] a, input logic [7:0] b);
    logic [7:0] d;
    d = (a >= b) ? (a - b) : (b - a);
    return d <= NEAR_LIMIT;
  endfunction

  assign slot     = !ov_r || pop;
  assign code     = q_data.code;
  assign pos      = cnt_r[2:0];
  assign bit_v    = pbits_r[pi_r];
  assign wbyte    = ((pos == 3'd0) ? 8'h00 : cur_r) | (bit_v ? (8'h80 >> pos) : 8'h00);
  assign cnt_inc  = cnt_r + 8'd1;
  assign last_idx = SAW'((cnt_r - 8'd1) >> 3);
  assign st_wr    = (state_r == B_PUSH);
  assign q_rd     = (state_r == B_IDLE) && !q_stat.empty;

  always_comb begin
    emit = 1'b0;
    eb   = 8'h00;
    el   = 1'b0;
    case (state_r)
      B_VAL1: begin
        emit = (first_r != 8'h00);
        eb   = first_r;
        el   = (second_r == 8'h00) && !tail_v_r;
      end
      B_VAL2: begin
        emit = (second_r != 8'h00);
        eb   = second_r;
        el   = !tail_v_r;
      end
      B_HDR: begin
        emit = 1'b1;
        case (hdr_r)
          2'd0:    eb = RUN_MARKER;
          2'd1:    eb = first_r;
          2'd2:    eb = second_r;
          default: eb = cnt_r;
        endcase
      end
      B_ST: begin
        emit = 1'b1;
        eb   = rdata_r;
        el   = (bi_r == last_idx) && !tail_v_r;
      end
      B_TAIL: begin
        emit = tail_v_r;
        eb   = tail_r;
        el   = 1'b1;
      end
      default: emit = 1'b0;
    endcase
  end

  // bit store
  always_ff @(posedge clk) begin
    if (st_wr) begin
      store[cnt_r[7:3]] <= wbyte;
    end
    rdata_r <= store[bi_r];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= B_IDLE;
      first_r  <= 8'h00;
      second_r <= 8'h00;
      cnt_r    <= 8'h00;
      ov_r     <= 1'b0;
    end else begin
      if (emit && slot) begin
        ov_r <= 1'b1;
        ob_r <= eb;
        ol_r <= el;
      end else if (pop && ov_r) begin
        ov_r <= 1'b0;
      end
      unique case (state_r)
        B_IDLE: begin
          if (!q_stat.empty) begin
            pi_r <= 2'd0;
            if (q_data.flush) begin
              tail_v_r <= 1'b0;
              after_r  <= 8'h00;
              state_r  <= B_END;
            end else if (code == 8'h00 || code == CODE_MAX) begin
              tail_v_r <= 1'b1;
              tail_r   <= code;
              after_r  <= 8'h00;
              state_r  <= B_END;
            end else if (first_r == 8'h00) begin
              first_r <= code;
            end else if (near_code(code, first_r)) begin
              if (cnt_r != 8'h00) begin
                pbits_r <= 3'b000;
                plast_r <= 2'd0;
              end else if (second_r != 8'h00) begin
                pbits_r <= 3'b010;
                plast_r <= 2'd2;
              end else begin
                pbits_r <= 3'b000;
                plast_r <= 2'd1;
              end
              state_r <= B_PUSH;
            end else if (second_r == 8'h00) begin
              second_r <= code;
              if (cnt_r != 8'h00) begin
                pbits_r <= 3'b001;
                plast_r <= 2'd0;
                state_r <= B_PUSH;
              end
            end else if (near_code(code, second_r)) begin
              if (cnt_r == 8'h00) begin
                pbits_r <= 3'b110;
                plast_r <= 2'd2;
              end else begin
                pbits_r <= 3'b001;
                plast_r <= 2'd0;
              end
              state_r <= B_PUSH;
            end else begin
              tail_v_r <= 1'b0;
              after_r  <= code;
              state_r  <= B_END;
            end
          end
        end
        B_PUSH: begin
          cur_r <= wbyte;
          cnt_r <= cnt_inc;
          if (cnt_inc == RUN_LIMIT) begin
            tail_v_r <= 1'b0;
            after_r  <= 8'h00;
            state_r  <= B_END;
          end else if (pi_r == plast_r) begin
            state_r <= B_IDLE;
          end else begin
            pi_r <= pi_r + 2'd1;
          end
        end
        B_END: begin
          hdr_r   <= 2'd0;
          state_r <= (cnt_r == 8'h00) ? B_VAL1 : B_HDR;
        end
        B_VAL1: begin
          if (!emit || slot) begin
            state_r <= B_VAL2;
          end
        end
        B_VAL2: begin
          if (!emit || slot) begin
            state_r <= B_TAIL;
          end
        end
        B_HDR: begin
          if (slot) begin
            if (hdr_r == 2'd3) begin
              bi_r    <= '0;
              state_r <= B_RD;
            end else begin
              hdr_r <= hdr_r + 2'd1;
            end
          end
        end
        B_RD: begin
          state_r <= B_ST;
        end
        B_ST: begin
          if (slot) begin
            if (bi_r == last_idx) begin
              state_r <= B_TAIL;
            end else begin
              bi_r    <= bi_r + 1'b1;
              state_r <= B_RD;
            end
          end
        end
        B_TAIL: begin
          if (!emit || slot) begin
            state_r <= B_FIN;
          end
        end
        B_FIN: begin
          first_r  <= after_r;
          second_r <= 8'h00;
          cnt_r    <= 8'h00;
          state_r  <= B_IDLE;
        end
        default: state_r <= B_IDLE;
      endcase
    end
  end

  assign empty    = !ov_r;
  assign out_byte = ob_r;
  assign out_last = ol_r;

endmodule

// ===== hw/rtl/ir_timing_packer.sv =====
// front: flush records and edge counts skip the threshold search, other tick counts run it
// back: codes, pushed bits, header bytes and stored run bytes each take their own steps
// throughput: one beat in flight in the front, no new beat until its record is in the queue
// the front search loop and the single read port of the bit store limit the throughput
// reset: synchronous active low, clears the run state, empties the queue and the output register
`include "assert_macros.svh"
// ----------------------------------------------------------------------------
// ir_timing_packer
// quantises ir edge tick counts and packs them into a run coded byte stream
// ----------------------------------------------------------------------------
module ir_timing_packer import itp_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        push,
  output logic        full,
  input  logic        in_operation,
  input  logic [15:0] in_ticks,
  output logic        empty,
  input  logic        pop,
  output logic [7:0]  out_byte,
  output logic        out_last
);

  logic       q_wr;
  itp_rec_t   q_wdata;
  logic       q_rd;
  itp_rec_t   q_rdata;
  itp_qstat_t q_stat;

  itp_front u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .push         (push),
    .full         (full),
    .in_operation (in_operation),
    .in_ticks     (in_ticks),
    .q_wr         (q_wr),
    .q_data       (q_wdata),
    .q_stat       (q_stat)
  );

  itp_queue u_queue (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_en   (q_wr),
    .wr_data (q_wdata),
    .rd_en   (q_rd),
    .rd_data (q_rdata),
    .stat    (q_stat)
  );

  itp_back u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .q_data   (q_rdata),
    .q_stat   (q_stat),
    .q_rd     (q_rd),
    .empty    (empty),
    .pop      (pop),
    .out_byte (out_byte),
    .out_last (out_last)
  );

  `ITP_ASSERT_RST(a_reset_idle, clk, !rst_n |=> (empty && !full), "not idle after reset")
  `ITP_ASSERT(a_busy_after_beat, clk, rst_n, (push && !full) |=> full, "front took two beats")
  `ITP_ASSERT(a_queue_rd_ok, clk, rst_n, q_rd |-> !q_stat.empty, "queue read while empty")

endmodule
